FILE: hw/rtl/e2c_pkg.sv
// Shared constants and types for the epoch to calendar converter.
package e2c_pkg;

   // pipeline depth and the stages where partial results settle
   localparam int NSTG        = 16;
   localparam int LAST_ST     = NSTG - 1;
   localparam int CLK_DONE_ST = 9;
   localparam int WD_DONE_ST  = 6;

   // one day of bias keeps the offset sum non-negative
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;

   // day split: seconds >> 7, then divide by 675
   localparam int unsigned DAY_DIV = 675;
   localparam int unsigned DAY_K   = 26;
   localparam int unsigned DAY_RCP = (2 ** DAY_K) / DAY_DIV;

   localparam int unsigned HR_K   = 17;
   localparam int unsigned HR_RCP = (2 ** HR_K) / SECS_PER_HOUR;
   localparam int unsigned MN_K   = 12;
   localparam int unsigned MN_RCP = (2 ** MN_K) / SECS_PER_MIN;

   localparam int unsigned DAYS_PER_WEEK = 7;
   localparam int unsigned WK_K          = 16;
   localparam int unsigned WK_RCP        = (2 ** WK_K) / DAYS_PER_WEEK;

   // civil date from days since 0000-03-01, 400-year eras
   localparam int unsigned DAYS_PER_ERA  = 146097;
   localparam int unsigned ERA5_DAY      = 11018;   // first day of the era that starts in 2000
   localparam int unsigned ERA4_OFS      = 135079;  // day-of-era of 1969-12-31
   localparam int unsigned DAYS_PER_4YR  = 1461;
   localparam int unsigned YR_K          = 18;
   localparam int unsigned YR_RCP        = (2 ** YR_K) / DAYS_PER_4YR;
   localparam int unsigned MO_DIV        = 153;
   localparam int unsigned MO_BIAS       = 461;
   localparam int unsigned MO_K          = 12;
   localparam int unsigned MO_RCP        = (2 ** MO_K) / MO_DIV;
   localparam int unsigned DY_DIV        = 5;
   localparam int unsigned DY_K          = 8;
   localparam int unsigned DY_RCP        = (2 ** DY_K) / DY_DIV;

   localparam int unsigned ERA4_YEAR     = 1600;
   localparam int unsigned ERA5_YEAR     = 2000;
   localparam int unsigned YEARS_PER_CEN = 100;
   localparam int unsigned WIN_FIRST     = 2000;
   localparam int unsigned WIN_LAST      = 2099;
   localparam int unsigned MONTHS        = 12;

   typedef logic [NSTG-1:0] stage_en_type;

   typedef struct packed {
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } hms_type;

   typedef struct packed {
      logic [2:0] weekday;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [6:0] year_in_century;
      logic       year_in_window;
   } date_type;

   // whole-hour offset in seconds
   function automatic logic signed [17:0] ofs_secs(input logic signed [4:0] hrs);
      logic signed [17:0] h;
      h = 18'(hrs);
      return h * 18'sd3600;
   endfunction

endpackage

FILE: hw/rtl/e2c_if.sv
// Valid/ready channel interfaces for request and response words.
interface e2c_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] hours;
   logic [5:0] minutes;
   logic [5:0] seconds;
   logic [2:0] weekday;
   logic [3:0] month;
   logic [4:0] day_of_month;
   logic [6:0] year_in_century;
   logic       year_in_window;

   modport source (output valid, output hours, output minutes, output seconds,
                   output weekday, output month, output day_of_month,
                   output year_in_century, output year_in_window, input ready);
   modport sink   (input valid, input hours, input minutes, input seconds,
                   input weekday, input month, input day_of_month,
                   input year_in_century, input year_in_window, output ready);
endinterface

FILE: hw/rtl/epoch_to_calendar_converter.sv
// 16-stage pipeline; a word is accepted into stage 0 and leaves from stage 15 when rsp ready
// is high. Throughput one word per cycle while rsp ready stays high;
// depth is set by the reciprocal-multiply divider stages.
// Stages hold independently: a bubble is filled even while the output word waits.
// Synchronous reset clears all stage valid bits and sets the zone offset to 0.
module epoch_to_calendar_converter (
   input  logic              clock,
   input  logic              reset,
   e2c_req_if.sink           req_if,
   e2c_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic signed [4:0] csr_wr_data
);

   logic signed [4:0]          zone_ff;
   logic [e2c_pkg::NSTG-1:0]   vld_ff;
   logic [e2c_pkg::NSTG-1:0]   vld_in;
   logic [e2c_pkg::NSTG:0]     rdy;
   e2c_pkg::stage_en_type      en;

   logic [16:0]                sod;
   logic [15:0]                days1;
   e2c_pkg::hms_type           hms;
   e2c_pkg::date_type          date;

   // a stage loads when empty or when the one after it loads
   always_comb begin
      rdy[e2c_pkg::NSTG] = rsp_if.ready;
      for (int i = e2c_pkg::NSTG - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] | rdy[i+1];
      end
      en     = rdy[e2c_pkg::NSTG-1:0];
      vld_in = {vld_ff[e2c_pkg::NSTG-2:0], req_if.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         zone_ff <= '0;
      end else begin
         for (int i = 0; i < e2c_pkg::NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
         if (csr_wr_en) begin
            zone_ff <= csr_wr_data;
         end
      end
   end

   e2c_split u_split (
      .clock             (clock),
      .en                (en),
      .epoch_seconds     (req_if.epoch_seconds),
      .zone_offset_hours (zone_ff),
      .sod               (sod),
      .days1             (days1)
   );

   e2c_clock u_clock (
      .clock (clock),
      .en    (en),
      .sod   (sod),
      .hms   (hms)
   );

   e2c_date u_date (
      .clock (clock),
      .en    (en),
      .days1 (days1),
      .date  (date)
   );

   assign req_if.ready           = rdy[0];
   assign rsp_if.valid           = vld_ff[e2c_pkg::LAST_ST];
   assign rsp_if.hours           = hms.hours;
   assign rsp_if.minutes         = hms.minutes;
   assign rsp_if.seconds         = hms.seconds;
   assign rsp_if.weekday         = date.weekday;
   assign rsp_if.month           = date.month;
   assign rsp_if.day_of_month    = date.day_of_month;
   assign rsp_if.year_in_century = date.year_in_century;
   assign rsp_if.year_in_window  = date.year_in_window;

endmodule

FILE: hw/rtl/e2c_split.sv
// Stages 0-3: zone offset add, then split into day count and second of day.
module e2c_split (
   input  logic                 clock,
   input  e2c_pkg::stage_en_type en,
   input  logic [31:0]          epoch_seconds,
   input  logic signed [4:0]    zone_offset_hours,
   output logic [16:0]          sod,
   output logic [15:0]          days1
);

   logic signed [33:0] t_in;
   logic [32:0]        u_in;
   logic [32:0]        u_ff;

   logic [42:0] dprod;
   logic [16:0] q0_in;
   logic [16:0] q1_ff;
   logic [25:0] v1_ff;
   logic [6:0]  lo1_ff;

   logic [26:0] rdiff;
   logic [10:0] r2_in;
   logic [10:0] r2_ff;
   logic [16:0] q2_ff;
   logic [6:0]  lo2_ff;

   logic [10:0] radj;
   logic [16:0] qadj;
   logic [16:0] sod_in;
   logic [15:0] days1_in;
   logic [16:0] sod_ff;
   logic [15:0] days1_ff;

   // biased by one day so the sum never goes negative
   always_comb begin
      t_in = signed'({2'b00, epoch_seconds}) + 34'(e2c_pkg::ofs_secs(zone_offset_hours))
             + 34'(e2c_pkg::SECS_PER_DAY);
      u_in = t_in[32:0];
   end

   // 86400 = 128 * 675
   always_comb begin
      dprod = 43'(u_ff[32:7]) * 43'(e2c_pkg::DAY_RCP);
      q0_in = dprod[42:26];
   end

   always_comb begin
      rdiff = 27'(v1_ff) - 27'(q1_ff) * 27'(e2c_pkg::DAY_DIV);
      r2_in = rdiff[10:0];
   end

   always_comb begin
      if (r2_ff >= 11'(e2c_pkg::DAY_DIV)) begin
         radj = r2_ff - 11'(e2c_pkg::DAY_DIV);
         qadj = q2_ff + 17'd1;
      end else begin
         radj = r2_ff;
         qadj = q2_ff;
      end
      sod_in   = {radj[9:0], lo2_ff};
      days1_in = qadj[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u_ff <= u_in;
      end
      if (en[1]) begin
         q1_ff  <= q0_in;
         v1_ff  <= u_ff[32:7];
         lo1_ff <= u_ff[6:0];
      end
      if (en[2]) begin
         r2_ff  <= r2_in;
         q2_ff  <= q1_ff;
         lo2_ff <= lo1_ff;
      end
      if (en[3]) begin
         sod_ff   <= sod_in;
         days1_ff <= days1_in;
      end
   end

   assign sod   = sod_ff;
   assign days1 = days1_ff;

endmodule

FILE: hw/rtl/e2c_clock.sv
// Stages 4-15: second of day to hours, minutes, seconds, then delay to the output stage.
module e2c_clock (
   input  logic                  clock,
   input  e2c_pkg::stage_en_type en,
   input  logic [16:0]           sod,
   output e2c_pkg::hms_type      hms
);

   logic [22:0] hprod;
   logic [5:0]  h0_in;
   logic [5:0]  h4_ff;
   logic [16:0] sod4_ff;

   logic [16:0] hdiff;
   logic [12:0] r5_in;
   logic [12:0] r5_ff;
   logic [5:0]  h5_ff;

   logic [4:0]  hr6_in;
   logic [11:0] soh6_in;
   logic [4:0]  hr6_ff;
   logic [11:0] soh6_ff;

   logic [18:0] mprod;
   logic [6:0]  m0_in;
   logic [6:0]  m7_ff;
   logic [11:0] soh7_ff;
   logic [4:0]  hr7_ff;

   logic [11:0] mdiff;
   logic [6:0]  r8_in;
   logic [6:0]  r8_ff;
   logic [6:0]  m8_ff;
   logic [4:0]  hr8_ff;

   e2c_pkg::hms_type hms9_in;
   e2c_pkg::hms_type hms9_ff;
   e2c_pkg::hms_type dly_ff [e2c_pkg::CLK_DONE_ST+1:e2c_pkg::LAST_ST];

   always_comb begin
      hprod = 23'(sod) * 23'(e2c_pkg::HR_RCP);
      h0_in = hprod[22:17];
   end

   always_comb begin
      hdiff = sod4_ff - 17'(h4_ff) * 17'(e2c_pkg::SECS_PER_HOUR);
      r5_in = hdiff[12:0];
   end

   always_comb begin
      if (r5_ff >= 13'(e2c_pkg::SECS_PER_HOUR)) begin
         hr6_in  = 5'(h5_ff + 6'd1);
         soh6_in = 12'(r5_ff - 13'(e2c_pkg::SECS_PER_HOUR));
      end else begin
         hr6_in  = h5_ff[4:0];
         soh6_in = r5_ff[11:0];
      end
   end

   always_comb begin
      mprod = 19'(soh6_ff) * 19'(e2c_pkg::MN_RCP);
      m0_in = mprod[18:12];
   end

   always_comb begin
      mdiff = soh7_ff - 12'(m7_ff) * 12'(e2c_pkg::SECS_PER_MIN);
      r8_in = mdiff[6:0];
   end

   always_comb begin
      hms9_in.hours = hr8_ff;
      if (r8_ff >= 7'(e2c_pkg::SECS_PER_MIN)) begin
         hms9_in.minutes = 6'(m8_ff + 7'd1);
         hms9_in.seconds = 6'(r8_ff - 7'(e2c_pkg::SECS_PER_MIN));
      end else begin
         hms9_in.minutes = m8_ff[5:0];
         hms9_in.seconds = r8_ff[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         h4_ff   <= h0_in;
         sod4_ff <= sod;
      end
      if (en[5]) begin
         r5_ff <= r5_in;
         h5_ff <= h4_ff;
      end
      if (en[6]) begin
         hr6_ff  <= hr6_in;
         soh6_ff <= soh6_in;
      end
      if (en[7]) begin
         m7_ff   <= m0_in;
         soh7_ff <= soh6_ff;
         hr7_ff  <= hr6_ff;
      end
      if (en[8]) begin
         r8_ff  <= r8_in;
         m8_ff  <= m7_ff;
         hr8_ff <= hr7_ff;
      end
      if (en[e2c_pkg::CLK_DONE_ST]) begin
         hms9_ff <= hms9_in;
      end
      if (en[e2c_pkg::CLK_DONE_ST+1]) begin
         dly_ff[e2c_pkg::CLK_DONE_ST+1] <= hms9_ff;
      end
      for (int i = e2c_pkg::CLK_DONE_ST + 2; i <= e2c_pkg::LAST_ST; i++) begin
         if (en[i]) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   assign hms = dly_ff[e2c_pkg::LAST_ST];

endmodule

FILE: hw/rtl/e2c_date.sv
// Stages 4-15: day count to weekday, month, day of month and two-digit year.
module e2c_date (
   input  logic                  clock,
   input  e2c_pkg::stage_en_type en,
   input  logic [15:0]           days1,
   output e2c_pkg::date_type     date
);

   // day of era and 4*doe+3
   logic        era5_in;
   logic [17:0] doe_in;
   logic [19:0] n4_ff;
   logic        era4_ff;

   logic [1:0]  c5_in;
   logic [19:0] nsub;
   logic [17:0] n1_5_in;
   logic [1:0]  c5_ff;
   logic [17:0] n1_5_ff;
   logic        era5_ff;

   logic [25:0] yprod;
   logic [7:0]  y0_in;
   logic [7:0]  y6_ff;
   logic [17:0] n1_6_ff;
   logic [1:0]  c6_ff;
   logic        era6_ff;

   logic [17:0] ydiff;
   logic [11:0] r7_in;
   logic [11:0] r7_ff;
   logic [7:0]  y7_ff;
   logic [1:0]  c7_ff;
   logic        era7_ff;

   logic [6:0]  y8_in;
   logic [11:0] rr8;
   logic [8:0]  ny8_in;
   logic [6:0]  y8_ff;
   logic [8:0]  ny8_ff;
   logic [1:0]  c8_ff;
   logic        era8_ff;

   logic [11:0] n2_9_in;
   logic [11:0] yb9_in;
   logic [11:0] n2_9_ff;
   logic [11:0] yb9_ff;

   logic [16:0] mprod;
   logic [4:0]  m0_in;
   logic [4:0]  m10_ff;
   logic [11:0] n2_10_ff;
   logic [11:0] yb10_ff;

   logic [11:0] mdiff;
   logic [8:0]  r11_in;
   logic [8:0]  r11_ff;
   logic [4:0]  m11_ff;
   logic [11:0] yb11_ff;

   logic [3:0]  mo12_in;
   logic [7:0]  dr12_in;
   logic [3:0]  mo12_ff;
   logic [7:0]  dr12_ff;
   logic [11:0] yb12_ff;

   logic [13:0] dprod;
   logic [5:0]  d0_in;
   logic [5:0]  d13_ff;
   logic [7:0]  dr13_ff;
   logic [3:0]  mo13_ff;
   logic [11:0] yb13_ff;

   logic [7:0]  ddiff;
   logic [4:0]  day14_in;
   logic [3:0]  mon14_in;
   logic [11:0] yr14_in;
   logic [4:0]  day14_ff;
   logic [3:0]  mon14_ff;
   logic [11:0] yr14_ff;

   logic        inwin;
   logic [11:0] yoff;

   // weekday path
   logic [15:0] wx_in;
   logic [29:0] wprod;
   logic [13:0] wq_in;
   logic [15:0] wx4_ff;
   logic [13:0] wq4_ff;
   logic [16:0] wdiff;
   logic [3:0]  wr5_in;
   logic [3:0]  wr5_ff;
   logic [2:0]  wd6_in;
   logic [2:0]  wd6_ff;
   logic [2:0]  wd_ff [e2c_pkg::WD_DONE_ST+1:e2c_pkg::LAST_ST-1];

   e2c_pkg::date_type date_in;
   e2c_pkg::date_type date_ff;

   always_comb begin
      era5_in = days1 >= 16'(e2c_pkg::ERA5_DAY);
      if (era5_in) begin
         doe_in = 18'(days1) - 18'(e2c_pkg::ERA5_DAY);
      end else begin
         doe_in = 18'(days1) + 18'(e2c_pkg::ERA4_OFS);
      end
   end

   // century of era by compare, then quarter of remainder
   always_comb begin
      if (n4_ff >= 20'(3 * e2c_pkg::DAYS_PER_ERA)) begin
         c5_in = 2'd3;
         nsub  = n4_ff - 20'(3 * e2c_pkg::DAYS_PER_ERA);
      end else if (n4_ff >= 20'(2 * e2c_pkg::DAYS_PER_ERA)) begin
         c5_in = 2'd2;
         nsub  = n4_ff - 20'(2 * e2c_pkg::DAYS_PER_ERA);
      end else if (n4_ff >= 20'(e2c_pkg::DAYS_PER_ERA)) begin
         c5_in = 2'd1;
         nsub  = n4_ff - 20'(e2c_pkg::DAYS_PER_ERA);
      end else begin
         c5_in = 2'd0;
         nsub  = n4_ff;
      end
      n1_5_in = {nsub[17:2], 2'b11};
   end

   always_comb begin
      yprod = 26'(n1_5_ff) * 26'(e2c_pkg::YR_RCP);
      y0_in = yprod[25:18];
   end

   always_comb begin
      ydiff = n1_6_ff - 18'(y6_ff) * 18'(e2c_pkg::DAYS_PER_4YR);
      r7_in = ydiff[11:0];
   end

   always_comb begin
      if (r7_ff >= 12'(e2c_pkg::DAYS_PER_4YR)) begin
         y8_in = 7'(y7_ff + 8'd1);
         rr8   = r7_ff - 12'(e2c_pkg::DAYS_PER_4YR);
      end else begin
         y8_in = y7_ff[6:0];
         rr8   = r7_ff;
      end
      ny8_in = rr8[10:2];
   end

   // year base counts from March; Jan and Feb bump it later
   always_comb begin
      n2_9_in = 12'(ny8_ff) * 12'(e2c_pkg::DY_DIV) + 12'(e2c_pkg::MO_BIAS);
      yb9_in  = (era8_ff ? 12'(e2c_pkg::ERA5_YEAR) : 12'(e2c_pkg::ERA4_YEAR))
                + 12'(c8_ff) * 12'(e2c_pkg::YEARS_PER_CEN) + 12'(y8_ff);
   end

   always_comb begin
      mprod = 17'(n2_9_ff) * 17'(e2c_pkg::MO_RCP);
      m0_in = mprod[16:12];
   end

   always_comb begin
      mdiff  = n2_10_ff - 12'(m10_ff) * 12'(e2c_pkg::MO_DIV);
      r11_in = mdiff[8:0];
   end

   always_comb begin
      if (r11_ff >= 9'(e2c_pkg::MO_DIV)) begin
         mo12_in = 4'(m11_ff + 5'd1);
         dr12_in = 8'(r11_ff - 9'(e2c_pkg::MO_DIV));
      end else begin
         mo12_in = m11_ff[3:0];
         dr12_in = r11_ff[7:0];
      end
   end

   always_comb begin
      dprod = 14'(dr12_ff) * 14'(e2c_pkg::DY_RCP);
      d0_in = dprod[13:8];
   end

   always_comb begin
      ddiff = dr13_ff - 8'(d13_ff) * 8'(e2c_pkg::DY_DIV);
      if (ddiff >= 8'(e2c_pkg::DY_DIV)) begin
         day14_in = 5'(d13_ff + 6'd2);
      end else begin
         day14_in = 5'(d13_ff + 6'd1);
      end
      if (mo13_ff > 4'(e2c_pkg::MONTHS)) begin
         mon14_in = mo13_ff - 4'(e2c_pkg::MONTHS);
         yr14_in  = yb13_ff + 12'd1;
      end else begin
         mon14_in = mo13_ff;
         yr14_in  = yb13_ff;
      end
   end

   always_comb begin
      inwin = (yr14_ff >= 12'(e2c_pkg::WIN_FIRST)) && (yr14_ff <= 12'(e2c_pkg::WIN_LAST));
      yoff  = yr14_ff - 12'(e2c_pkg::WIN_FIRST);
      date_in.weekday         = wd_ff[e2c_pkg::LAST_ST-1];
      date_in.month           = mon14_ff;
      date_in.day_of_month    = day14_ff;
      date_in.year_in_century = inwin ? yoff[6:0] : 7'd0;
      date_in.year_in_window  = inwin;
   end

   // Thursday start: weekday = (days + 3) mod 7 + 1, days1 = days + 1
   always_comb begin
      wx_in = days1 + 16'd2;
      wprod = 30'(wx_in) * 30'(e2c_pkg::WK_RCP);
      wq_in = wprod[29:16];
   end

   always_comb begin
      wdiff  = 17'(wx4_ff) - 17'(wq4_ff) * 17'(e2c_pkg::DAYS_PER_WEEK);
      wr5_in = wdiff[3:0];
   end

   always_comb begin
      if (wr5_ff >= 4'(e2c_pkg::DAYS_PER_WEEK)) begin
         wd6_in = 3'(wr5_ff - 4'(e2c_pkg::DAYS_PER_WEEK) + 4'd1);
      end else begin
         wd6_in = 3'(wr5_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         n4_ff   <= {doe_in, 2'b11};
         era4_ff <= era5_in;
         wx4_ff  <= wx_in;
         wq4_ff  <= wq_in;
      end
      if (en[5]) begin
         c5_ff   <= c5_in;
         n1_5_ff <= n1_5_in;
         era5_ff <= era4_ff;
         wr5_ff  <= wr5_in;
      end
      if (en[e2c_pkg::WD_DONE_ST]) begin
         y6_ff   <= y0_in;
         n1_6_ff <= n1_5_ff;
         c6_ff   <= c5_ff;
         era6_ff <= era5_ff;
         wd6_ff  <= wd6_in;
      end
      if (en[7]) begin
         r7_ff   <= r7_in;
         y7_ff   <= y6_ff;
         c7_ff   <= c6_ff;
         era7_ff <= era6_ff;
      end
      if (en[8]) begin
         y8_ff   <= y8_in;
         ny8_ff  <= ny8_in;
         c8_ff   <= c7_ff;
         era8_ff <= era7_ff;
      end
      if (en[9]) begin
         n2_9_ff <= n2_9_in;
         yb9_ff  <= yb9_in;
      end
      if (en[10]) begin
         m10_ff   <= m0_in;
         n2_10_ff <= n2_9_ff;
         yb10_ff  <= yb9_ff;
      end
      if (en[11]) begin
         r11_ff  <= r11_in;
         m11_ff  <= m10_ff;
         yb11_ff <= yb10_ff;
      end
      if (en[12]) begin
         mo12_ff <= mo12_in;
         dr12_ff <= dr12_in;
         yb12_ff <= yb11_ff;
      end
      if (en[13]) begin
         d13_ff  <= d0_in;
         dr13_ff <= dr12_ff;
         mo13_ff <= mo12_ff;
         yb13_ff <= yb12_ff;
      end
      if (en[14]) begin
         day14_ff <= day14_in;
         mon14_ff <= mon14_in;
         yr14_ff  <= yr14_in;
      end
      if (en[e2c_pkg::LAST_ST]) begin
         date_ff <= date_in;
      end
      if (en[e2c_pkg::WD_DONE_ST+1]) begin
         wd_ff[e2c_pkg::WD_DONE_ST+1] <= wd6_ff;
      end
      for (int i = e2c_pkg::WD_DONE_ST + 2; i <= e2c_pkg::LAST_ST - 1; i++) begin
         if (en[i]) begin
            wd_ff[i] <= wd_ff[i-1];
         end
      end
   end

   assign date = date_ff;

endmodule

FILE: hw/rtl/e2c_checker.sv
// Port-level checks for the converter, bound to the top level.
module e2c_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] hours,
   input logic [5:0] minutes,
   input logic [5:0] seconds,
   input logic [2:0] weekday,
   input logic [3:0] month,
   input logic [4:0] day_of_month,
   input logic [6:0] year_in_century,
   input logic       year_in_window
);

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hours) && $stable(minutes)
         && $stable(seconds) && $stable(weekday) && $stable(month)
         && $stable(day_of_month) && $stable(year_in_century) && $stable(year_in_window))
      else $error("response word changed while stalled");

   // a ready sink or an empty output register never backpressures the source
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("input stalled with output free");

   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hours < 5'd24 && minutes < 6'd60 && seconds < 6'd60
         && weekday >= 3'd1 && weekday <= 3'd7 && month >= 4'd1 && month <= 4'd12
         && day_of_month >= 5'd1 && year_in_century <= 7'd99)
      else $error("calendar field out of range");

   a_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !year_in_window |-> year_in_century == 7'd0)
      else $error("year outside window not zeroed");

endmodule

bind epoch_to_calendar_converter e2c_checker u_e2c_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .hours           (rsp_if.hours),
   .minutes         (rsp_if.minutes),
   .seconds         (rsp_if.seconds),
   .weekday         (rsp_if.weekday),
   .month           (rsp_if.month),
   .day_of_month    (rsp_if.day_of_month),
   .year_in_century (rsp_if.year_in_century),
   .year_in_window  (rsp_if.year_in_window)
);
